FILE: sv/assert_macros.svh
// Assertion shorthands clocked on clk, idle while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/fcd_pkg.sv
`timescale 1ns / 1ps
package fcd_pkg;

  localparam int DW       = 16;          // component width
  localparam int PW       = 2 * DW;      // product width
  localparam int SW       = PW + 1;      // exact cross-product sum width
  localparam int FBW      = 4;           // radix register width
  localparam int NDIV     = PW;          // one quotient bit per divider stage
  localparam int NSTG     = NDIV + 3;    // product, sum, divider, output
  localparam int IN_TW    = 4 * DW;
  localparam int OUT_TW   = 2 * DW;

  localparam logic [FBW-1:0] FB_RESET = FBW'(12);

  typedef logic signed [DW-1:0] comp_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [SW-1:0] sum_t;
  typedef logic        [PW-1:0] word_t;

endpackage

FILE: sv/fixed_point_complex_divider_top.sv
// Pipeline: each input beat passes through, in order,
//   1 product stage, 1 sum/scale stage, 32 restoring divider stages, 1 output stage.
// Throughput: one beat per cycle while out_tready is high; each stage holds one item and bubbles collapse on stall.
// Reset: synchronous active-low rst_n clears all valid bits and sets fraction_bits to 12.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fixed_point_complex_divider_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fcd_pkg::FBW-1:0]    cfg_data,    // fraction_bits
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [15:0] dividend_real, [31:16] dividend_imag, [47:32] divisor_real, [63:48] divisor_imag
  input  logic [fcd_pkg::IN_TW-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [15:0] quotient_real, [31:16] quotient_imag
  output logic [fcd_pkg::OUT_TW-1:0] out_tdata,
  output logic                       out_tuser    // divide_by_zero
);
  import fcd_pkg::*;

  logic [FBW-1:0] fb_r;
  logic [NSTG-1:0] v_r, v_nxt;
  logic [NSTG:0]   rdy;

  // product stage
  prod_t p_rr_r, p_ii_r, p_ir_r, p_ri_r, m_r_r, m_i_r;
  comp_t dr, di, vr, vi;

  // divider datapath, index 0 written by the sum stage
  word_t rre_r [0:NDIV];
  word_t rim_r [0:NDIV];
  word_t nqre_r [0:NDIV];
  word_t nqim_r [0:NDIV];
  word_t d_r   [0:NDIV];
  logic  nre_r [0:NDIV];
  logic  nim_r [0:NDIV];
  logic  z_r   [0:NDIV];

  sum_t  sum_re, sum_im;
  word_t mag, scaled;

  comp_t q_re, q_im;
  comp_t qre_r, qim_r;
  logic  dbz_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r <= FB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      fb_r <= cfg_data;
    end
  end

  // valid / ready chain
  assign rdy[NSTG] = out_tready;
  genvar k;
  generate
    for (k = 0; k < NSTG; k++) begin : g_hs
      assign rdy[k] = !v_r[k] || rdy[k+1];
      if (k == 0) begin : g_first
        assign v_nxt[k] = rdy[k] ? in_tvalid : v_r[k];
      end else begin : g_rest
        assign v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready = rdy[0];

  // stage 0: products
  assign dr = comp_t'(in_tdata[DW-1:0]);
  assign di = comp_t'(in_tdata[2*DW-1:DW]);
  assign vr = comp_t'(in_tdata[3*DW-1:2*DW]);
  assign vi = comp_t'(in_tdata[4*DW-1:3*DW]);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p_rr_r <= dr * vr;
      p_ii_r <= di * vi;
      p_ir_r <= di * vr;
      p_ri_r <= dr * vi;
      m_r_r  <= vr * vr;
      m_i_r  <= vi * vi;
    end
  end

  // stage 1: exact sums, squared magnitude, scaled divisor
  always_comb begin
    sum_re = sum_t'(p_rr_r) + sum_t'(p_ii_r);
    sum_im = sum_t'(p_ir_r) - sum_t'(p_ri_r);
    mag    = word_t'(m_r_r) + word_t'(m_i_r);
    scaled = mag >> fb_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      rre_r[0]  <= '0;
      rim_r[0]  <= '0;
      nqre_r[0] <= sum_re[SW-1] ? word_t'(-sum_re) : word_t'(sum_re);
      nqim_r[0] <= sum_im[SW-1] ? word_t'(-sum_im) : word_t'(sum_im);
      nre_r[0]  <= sum_re[SW-1];
      nim_r[0]  <= sum_im[SW-1];
      d_r[0]    <= scaled;
      z_r[0]    <= (scaled == '0);
    end
  end

  // restoring divider, one quotient bit per stage
  genvar j;
  generate
    for (j = 0; j < NDIV; j++) begin : g_div
      logic [PW:0] t_re, t_im;
      logic        ge_re, ge_im;
      word_t       rre_nxt, rim_nxt;

      always_comb begin
        t_re    = {rre_r[j], nqre_r[j][PW-1]};
        t_im    = {rim_r[j], nqim_r[j][PW-1]};
        ge_re   = t_re >= {1'b0, d_r[j]};
        ge_im   = t_im >= {1'b0, d_r[j]};
        rre_nxt = ge_re ? word_t'(t_re - {1'b0, d_r[j]}) : word_t'(t_re);
        rim_nxt = ge_im ? word_t'(t_im - {1'b0, d_r[j]}) : word_t'(t_im);
      end

      always_ff @(posedge clk) begin
        if (rdy[j+2]) begin
          rre_r[j+1]  <= rre_nxt;
          rim_r[j+1]  <= rim_nxt;
          nqre_r[j+1] <= {nqre_r[j][PW-2:0], ge_re};
          nqim_r[j+1] <= {nqim_r[j][PW-2:0], ge_im};
          d_r[j+1]    <= d_r[j];
          nre_r[j+1]  <= nre_r[j];
          nim_r[j+1]  <= nim_r[j];
          z_r[j+1]    <= z_r[j];
        end
      end
    end
  endgenerate

  // output stage: sign, wrap to 16 bits, zero on divide by zero
  always_comb begin
    q_re = comp_t'(nqre_r[NDIV][DW-1:0]);
    q_im = comp_t'(nqim_r[NDIV][DW-1:0]);
    if (nre_r[NDIV]) q_re = -q_re;
    if (nim_r[NDIV]) q_im = -q_im;
    if (z_r[NDIV]) begin
      q_re = '0;
      q_im = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTG-1]) begin
      qre_r <= q_re;
      qim_r <= q_im;
      dbz_r <= z_r[NDIV];
    end
  end

  assign out_tvalid = v_r[NSTG-1];
  assign out_tdata  = {qim_r, qre_r};
  assign out_tuser  = dbz_r;

  `ASSERT_IMPLIES(a_dbz_zero, out_tvalid && out_tuser, out_tdata == '0, "dbz with nonzero quotient")
  `ASSERT_IMPLIES(a_rem_lt_div, v_r[NSTG-2] && !z_r[NDIV], (rre_r[NDIV] < d_r[NDIV]) && (rim_r[NDIV] < d_r[NDIV]), "remainder not below divisor")
  `ASSERT_IMPLIES(a_full_stall, !in_tready, (&v_r) && !out_tready, "input stalled with a free stage")

endmodule

FILE: tb/sv/fixed_point_complex_divider_top_tb.sv
`timescale 1ns / 1ps
module fixed_point_complex_divider_top_tb;
  import fcd_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int LATENCY_SLACK = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 144;
  localparam int LIMIT = 400000;
  localparam int IDLE_PCT = 38;

  typedef struct packed {
    comp_t re;
    comp_t im;
    logic  dbz;
  } quotient_t;

  class quotient_scoreboard;
    quotient_t   expected_q[$];
    logic [FBW-1:0] frac_bits;
    int          errors;
    int          items;
    int          results;
    int          dbz_count;
    int          wrap_count;

    function new();
      frac_bits = FB_RESET;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void report(string what, quotient_t e, quotient_t a);
      errors++;
      if (errors <= 10)
        $display("[%0t] %s: expected re=%0d im=%0d dbz=%0b, got re=%0d im=%0d dbz=%0b",
                 $time, what, $signed(e.re), $signed(e.im), e.dbz,
                 $signed(a.re), $signed(a.im), a.dbz);
    endfunction

    // Exact complex division: cross sums over the scaled squared divisor magnitude.
    function void note_input(logic [IN_TW-1:0] beat);
      comp_t     dr, di, vr, vi;
      longint    ldr, ldi, lvr, lvi, mag, scaled, q_re, q_im;
      quotient_t e;
      dr = beat[15:0];
      di = beat[31:16];
      vr = beat[47:32];
      vi = beat[63:48];
      ldr = dr;
      ldi = di;
      lvr = vr;
      lvi = vi;
      mag = lvr * lvr + lvi * lvi;
      scaled = mag >> frac_bits;
      items++;
      if (scaled == 0) begin
        e = '{re: '0, im: '0, dbz: 1'b1};
        dbz_count++;
      end else begin
        q_re = (ldr * lvr + ldi * lvi) / scaled;
        q_im = (ldi * lvr - ldr * lvi) / scaled;
        if (q_re > 32767 || q_re < -32768 || q_im > 32767 || q_im < -32768)
          wrap_count++;
        e = '{re: q_re[15:0], im: q_im[15:0], dbz: 1'b0};
      end
      expected_q.push_back(e);
    endfunction

    function void check_result(logic [OUT_TW-1:0] data, logic dbz);
      quotient_t a, e;
      a = '{re: data[15:0], im: data[31:16], dbz: dbz};
      results++;
      if (expected_q.size() == 0) begin
        report("result beat with nothing expected", '0, a);
        return;
      end
      e = expected_q.pop_front();
      if (a.re !== e.re || a.im !== e.im || a.dbz !== e.dbz)
        report("quotient mismatch", e, a);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [FBW-1:0] cfg_data;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TW-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TW-1:0] out_tdata;
  logic out_tuser;

  quotient_scoreboard sb;
  int   cycle_count = 0;
  int   settings_used = 0;
  bit   tx_steady = 0;
  bit   rx_steady = 0;
  bit   hold_req = 0;
  bit   hold_done = 0;

  localparam comp_t CORNERS [7] = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1,
                                    16'sd32766, 16'sd32767};

  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  fixed_point_complex_divider_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  function automatic logic [IN_TW-1:0] pack_item(int dr, int di, int vr, int vi);
    return {vi[15:0], vr[15:0], di[15:0], dr[15:0]};
  endfunction

  function automatic logic [IN_TW-1:0] rand_item(logic [FBW-1:0] fb);
    comp_t       f[4];
    int          kind;
    int          a;
    logic [15:0] r;
    kind = $urandom_range(99);
    for (int k = 0; k < 4; k++) begin
      r = 16'($urandom);
      if (kind < 35)
        f[k] = r;
      else if (kind < 70)
        f[k] = comp_t'($signed(r) >>> $urandom_range(15, 0));
      else
        f[k] = CORNERS[$urandom_range(6, 0)];
    end
    if (kind >= 80 && kind < 88) begin
      // zero or tiny divisor
      f[2] = comp_t'($signed(16'($urandom)) >>> 13);
      f[3] = ($urandom_range(1) == 1) ? comp_t'(0) : comp_t'($signed(16'($urandom)) >>> 14);
    end else if (kind >= 88) begin
      // divisor magnitude right around the radix threshold
      a = 1 << (fb >> 1);
      f[2] = comp_t'(a + $urandom_range(2) - 1);
      f[3] = comp_t'((fb[0] ? a : 0) + $urandom_range(2) - 1);
      if ($urandom_range(1) == 1) f[2] = -f[2];
      if ($urandom_range(1) == 1) f[3] = -f[3];
    end
    return {f[3], f[2], f[1], f[0]};
  endfunction

  task automatic send_beat(input logic [IN_TW-1:0] beat);
    int gap;
    gap = 0;
    if (!tx_steady) while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(beat);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY_SLACK) @(posedge clk);
  endtask

  task automatic write_frac_bits(input logic [FBW-1:0] fb);
    cfg_valid <= 1'b1;
    cfg_data <= fb;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.frac_bits = fb;
    settings_used++;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
        if (hold_left == 0) hold_done = 1;
      end else if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    wait (cycle_count >= LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [FBW-1:0] plan [8];
    sb = new();
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset radix
    send_beat(pack_item(0, 0, 0, 0));
    send_beat(pack_item(32767, -32768, 0, 0));
    send_beat(pack_item(1000, -1000, 10, 20));
    send_beat(pack_item(4096, 0, 4096, 0));
    send_beat(pack_item(-32768, -32768, -32768, -32768));
    send_beat(pack_item(32767, 32767, -32768, 32767));
    send_beat(pack_item(-32768, 32767, 1, -1));
    send_beat(pack_item(32767, -32768, 64, 0));
    send_beat(pack_item(-1, -1, -1, -1));
    send_beat(pack_item(-32768, 0, 0, -32768));
    send_beat(pack_item(12345, -23456, -300, 700));
    send_beat(pack_item(0, 0, 32767, -32768));
    drain();

    write_frac_bits(4'd15);
    send_beat(pack_item(32767, -32768, 181, 0));
    send_beat(pack_item(32767, -32768, 182, 0));
    send_beat(pack_item(-32768, -32768, -32768, -32768));
    send_beat(pack_item(32767, 32767, 32767, 32767));
    send_beat(pack_item(-1, 1, -32768, 32767));
    send_beat(pack_item(100, -100, -32768, 0));
    drain();

    write_frac_bits(4'd0);
    send_beat(pack_item(1, 0, 1, 0));
    send_beat(pack_item(-32768, -32768, 1, 1));
    send_beat(pack_item(32767, -32768, -1, 0));
    send_beat(pack_item(5, -7, 3, 2));
    send_beat(pack_item(0, 0, 0, 1));
    send_beat(pack_item(-32768, 32767, 32767, -32768));
    drain();

    plan = '{4'd15, 4'd0, 4'($urandom), 4'd12, 4'($urandom), 4'd1, 4'd14, 4'($urandom)};
    for (int p = 0; p < 8; p++) begin
      write_frac_bits(plan[p]);
      tx_steady = (p == 3);
      rx_steady = (p == 3);
      if (p == 1) hold_req = 1;
      for (int i = 0; i < PHASE_ITEMS; i++) send_beat(rand_item(plan[p]));
      drain();
    end

    $display("%0d items over %0d radix settings, %0d results checked", sb.items,
             settings_used + 1, sb.results);
    $display("%0d zero-magnitude divisors, %0d wrapped quotients, hold-off %s, %0d errors",
             sb.dbz_count, sb.wrap_count, hold_done ? "done" : "missed", sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
